>>> rtl/md5_pkg.sv
// Package: MD5 engine types, constants and round tables.
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] PAD_WORD = 32'h00000080;

    typedef enum logic [2:0] {
        WSEL_DATA = 3'd0,
        WSEL_ZERO = 3'd1,
        WSEL_LEN_LO = 3'd2,
        WSEL_LEN_HI = 3'd3,
        WSEL_PAD80 = 3'd4
    } wsel_t;

    typedef struct packed {
        logic  load;      // capture input item
        logic  put;       // write one word into the buffer
        wsel_t wsel;
        logic  start;     // begin compression
        logic  reinit;    // restore chaining words, clear length and word index
    } md5_cmd_t;

    typedef struct packed {
        logic       busy;     // compression running
        logic [3:0] widx;
        logic       last;
        logic       pend80;   // full last word: 0x80 word still due
    } md5_sts_t;

    function automatic logic [31:0] sine_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [3:0] i);
        logic [4:0] s;
        unique case (i)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/md5_hash_engine_core.sv
// Top level: MD5 digest engine with stream input and two-item digest output.
// Each input item carries one little-endian 32-bit message word. An item that does
// not fill a 16-word block is written to the buffer; one that completes a block
// also starts the 64 rounds, computed one round per cycle in a single round unit. The
// last item of a message adds padding writes and one or two further compressions,
// after which the digest leaves as two 64-bit items, bytes 0-7 then bytes 8-15 with
// tlast set. The engine then reinitializes for the next message.
module md5_hash_engine_core
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zeros[39:35]
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_part[63:0]
    output logic        m_tlast    // final_part
);

    md5_cmd_t     cmd;
    md5_sts_t     sts;
    logic [127:0] digest;
    logic         out_sel, out_cap;

    md5_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_tdata[31:0]),
        .in_bytes (s_tdata[34:32]),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .sts      (sts),
        .digest   (digest)
    );

    md5_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sel   (out_sel),
        .out_cap   (out_cap),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tdata = (out_sel || out_cap) ? digest[127:64] : digest[63:0];
    assign m_tlast = out_sel;

endmodule

>>> rtl/md5_datapath.sv
// Datapath: input capture, block buffer, length counter and 64-round compression unit.
module md5_datapath
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] in_data,
    input  logic [2:0]  in_bytes,
    input  logic        in_last,
    input  md5_cmd_t    cmd,
    output md5_sts_t    sts,
    output logic [127:0] digest
);

    logic [31:0] blk_mem [16];
    logic [31:0] word_reg, word_next;
    logic        last_reg, pend_reg, pend_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  widx_reg;
    logic        busy_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] put_w;
    logic [31:0] f_val, sum, rot;
    logic [3:0]  g_idx;
    logic [2:0]  nb;
    logic [63:0] bits;

    always_comb begin
        nb = (in_bytes > 3'd4) ? 3'd4 : in_bytes;
        word_next = in_data;
        pend_next = 1'b0;
        len_next  = len_reg + 64'd4;
        if (in_last) begin
            len_next = len_reg + {61'd0, nb};
            unique case (nb)
                3'd0: word_next = PAD_WORD;
                3'd1: word_next = {16'd0, 8'h80, in_data[7:0]};
                3'd2: word_next = {8'd0, 8'h80, in_data[15:0]};
                3'd3: word_next = {8'h80, in_data[23:0]};
                default: begin
                    word_next = in_data;
                    pend_next = 1'b1;
                end
            endcase
        end
    end

    assign bits = {len_reg[60:0], 3'b000};

    always_comb begin
        unique case (cmd.wsel)
            WSEL_DATA:   put_w = word_reg;
            WSEL_PAD80:  put_w = PAD_WORD;
            WSEL_ZERO:   put_w = '0;
            WSEL_LEN_LO: put_w = bits[31:0];
            default:     put_w = bits[63:32];
        endcase
    end

    always_comb begin
        unique case (rnd_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = rnd_reg[3:0];
            end
            2'd1: begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = 4'({rnd_reg[3:0], 2'b00} + {2'b00, rnd_reg[3:0]} + 6'd1);
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'({rnd_reg[3:0], 1'b0} + {1'b0, rnd_reg[3:0]} + 5'd5);
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'({rnd_reg[3:0], 3'b000} - {3'b000, rnd_reg[3:0]});
            end
        endcase
        sum = a_reg + f_val + sine_k(rnd_reg) + blk_mem[g_idx];
        rot = 32'(({sum, sum} << rot_amt({rnd_reg[5:4], rnd_reg[1:0]})) >> 32);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg <= word_next;
            last_reg <= in_last;
        end
        if (cmd.put) begin
            blk_mem[widx_reg] <= put_w;
        end
        if (cmd.start) begin
            a_reg <= ca_reg; b_reg <= cb_reg; c_reg <= cc_reg; d_reg <= cd_reg;
        end else if (busy_reg) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            widx_reg <= '0;
            pend_reg <= 1'b0;
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            ca_reg <= INIT_A; cb_reg <= INIT_B; cc_reg <= INIT_C; cd_reg <= INIT_D;
        end else begin
            if (cmd.load) begin
                len_reg  <= len_next;
                pend_reg <= pend_next;
            end else if (cmd.put && cmd.wsel == WSEL_PAD80) begin
                pend_reg <= 1'b0;
            end
            if (cmd.put) begin
                widx_reg <= widx_reg + 4'd1;
            end
            if (cmd.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    ca_reg <= ca_reg + d_reg;
                    cb_reg <= cb_reg + b_reg + rot;
                    cc_reg <= cc_reg + b_reg;
                    cd_reg <= cd_reg + c_reg;
                end
            end
            if (cmd.reinit) begin
                ca_reg <= INIT_A; cb_reg <= INIT_B; cc_reg <= INIT_C; cd_reg <= INIT_D;
                len_reg  <= '0;
                widx_reg <= '0;
            end
        end
    end

    assign sts.busy   = busy_reg;
    assign sts.widx   = widx_reg;
    assign sts.last   = last_reg;
    assign sts.pend80 = pend_reg;
    assign digest = {cd_reg, cc_reg, cb_reg, ca_reg};

endmodule

>>> rtl/md5_ctrl.sv
// Controller: sequences word writes, padding, compressions and digest output.
module md5_ctrl
    import md5_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     out_sel,
    output logic     out_cap,
    output md5_cmd_t cmd,
    input  md5_sts_t sts
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PUT   = 7'b0000010,
        ST_PAD80 = 7'b0000100,
        ST_PAD   = 7'b0001000,
        ST_COMP  = 7'b0010000,
        ST_OUT0  = 7'b0100000,
        ST_OUT1  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   tail_reg, tail_next;
    logic   fit_reg, fit_next;
    logic   wrap;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign out_sel   = (state_reg == ST_OUT1);
    assign out_cap   = 1'b0;
    assign wrap      = (sts.widx == 4'd15);

    always_comb begin
        state_next = state_reg;
        tail_next  = tail_reg;
        fit_next   = fit_reg;
        cmd = '0;
        cmd.wsel = WSEL_DATA;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                cmd.put = 1'b1;
                tail_next = 1'b0;
                if (wrap) begin
                    cmd.start  = 1'b1;
                    state_next = ST_COMP;
                    tail_next  = sts.last;
                end else if (sts.last) begin
                    state_next = sts.pend80 ? ST_PAD80 : ST_PAD;
                    fit_next   = (sts.widx != 4'd14);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD80: begin
                cmd.put  = 1'b1;
                cmd.wsel = WSEL_PAD80;
                state_next = ST_PAD;
                fit_next   = (sts.widx != 4'd14);
                if (wrap) begin
                    cmd.start  = 1'b1;
                    state_next = ST_COMP;
                    tail_next  = 1'b1;
                end
            end
            ST_PAD: begin
                cmd.put  = 1'b1;
                cmd.wsel = (fit_reg && sts.widx == 4'd14) ? WSEL_LEN_LO :
                           (fit_reg && sts.widx == 4'd15) ? WSEL_LEN_HI : WSEL_ZERO;
                if (wrap) begin
                    cmd.start  = 1'b1;
                    state_next = ST_COMP;
                    tail_next  = !fit_reg;
                end
            end
            ST_COMP: begin
                if (!sts.busy) begin
                    if (tail_reg) begin
                        state_next = sts.pend80 ? ST_PAD80 : ST_PAD;
                        fit_next   = 1'b1;
                    end else if (sts.last) begin
                        state_next = ST_OUT0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT0: begin
                if (out_ready) begin
                    state_next = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (out_ready) begin
                    cmd.reinit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tail_reg  <= 1'b0;
            fit_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            fit_reg   <= fit_next;
        end
    end

endmodule

>>> test/md5_hash_engine_core_tb.sv
// Testbench: MD5 engine stream checks against a built-in digest predictor.
module md5_hash_engine_core_tb;
    import md5_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        has_exp;
        logic [63:0] exp0;
        logic [63:0] exp1;
    } stim_row_t;

    typedef struct {
        logic [63:0] part;
        logic        fin;
    } digest_item_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1530;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    logic [31:0] hash_a, hash_b, hash_c, hash_d;
    logic [31:0] msg_buf [16];
    int unsigned msg_idx;
    logic [63:0] msg_len;

    digest_item_t digest_q[$];
    stim_row_t    rows[$];
    int  errors;
    bit  stim_done;
    bit  hold_long;
    bit  quiet;
    int  idle_cnt;
    int  rx_gap;

    md5_hash_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t, sum;
        int g, grp;
        a = hash_a; b = hash_b; c = hash_c; d = hash_d;
        for (int r = 0; r < 64; r++) begin
            grp = r >> 4;
            case (grp)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) & 15; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) & 15; end
                default: begin f = c ^ (b | ~d); g = (7 * r) & 15; end
            endcase
            t = d;
            sum = a + f + sine_k(6'(r)) + msg_buf[g];
            d = c;
            c = b;
            b = b + rotl(sum, int'(rot_amt(4'((grp << 2) | (r & 3)))));
            a = t;
        end
        hash_a += a; hash_b += b; hash_c += c; hash_d += d;
    endtask

    task automatic buf_put(logic [31:0] w);
        msg_buf[msg_idx] = w;
        msg_idx = (msg_idx + 1) & 15;
        if (msg_idx == 0) md5_compress();
    endtask

    task automatic digest_reinit();
        hash_a = INIT_A; hash_b = INIT_B; hash_c = INIT_C; hash_d = INIT_D;
        msg_idx = 0;
        msg_len = '0;
    endtask

    task automatic predict_word(logic [31:0] w, logic [2:0] nb, logic last,
                                output logic [63:0] d0, output logic [63:0] d1);
        int n;
        logic [31:0] mask;
        logic [63:0] bits;
        d0 = '0; d1 = '0;
        if (!last) begin
            msg_len += 4;
            buf_put(w);
            return;
        end
        n = (nb > 4) ? 4 : int'(nb);
        msg_len += n;
        if (n == 4) begin
            buf_put(w);
            buf_put(PAD_WORD);
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
            buf_put((w & mask) | (PAD_WORD << (8 * n)));
        end
        if (msg_idx > 14) while (msg_idx != 0) buf_put(32'h0);
        while (msg_idx < 14) buf_put(32'h0);
        bits = msg_len << 3;
        buf_put(bits[31:0]);
        buf_put(bits[63:32]);
        d0 = {hash_b, hash_a};
        d1 = {hash_d, hash_c};
        digest_reinit();
    endtask

    task automatic add_row(logic [31:0] w, logic [2:0] nb, logic last);
        stim_row_t r;
        r.word = w; r.nbytes = nb; r.last = last; r.has_exp = 1'b0;
        r.exp0 = '0; r.exp1 = '0;
        rows.push_back(r);
    endtask

    task automatic add_msg(int nwords);
        for (int i = 0; i < nwords; i++) add_row($urandom(), 3'($urandom_range(0, 7)), 1'b0);
        add_row($urandom(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic send_item(stim_row_t r);
        logic [63:0] d0, d1;
        digest_item_t e;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.nbytes, r.word};
        s_tlast  <= r.last;
        @(posedge aclk iff s_tready);
        predict_word(r.word, r.nbytes, r.last, d0, d1);
        if (r.last) begin
            if (r.has_exp && (d0 !== r.exp0 || d1 !== r.exp1)) begin
                $error("table digest: expected %h %h, predictor %h %h", r.exp0, r.exp1, d0, d1);
                errors++;
            end
            e.part = d0; e.fin = 1'b0; digest_q.push_back(e);
            e.part = d1; e.fin = 1'b1; digest_q.push_back(e);
        end
    endtask

    initial begin
        stim_row_t r;
        int n;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        errors = 0;
        stim_done = 0;
        quiet = 0;
        digest_reinit();
        for (int i = 0; i < 16; i++) msg_buf[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message and "abc"
        r = '{32'hdeadbeef, 3'd0, 1'b1, 1'b1,
              64'h04b2008fd98c1dd4, 64'h7e42f8ec980980e9};
        rows.push_back(r);
        r = '{32'h00636261, 3'd3, 1'b1, 1'b1,
              64'hb04fd23c98500190, 64'h727fe1287d3f96d6};
        rows.push_back(r);
        add_row(32'hffffffff, 3'd7, 1'b1);
        add_row(32'hffffffff, 3'd5, 1'b1);
        add_row(32'h00000000, 3'd4, 1'b1);
        add_row(32'hffffffff, 3'd1, 1'b1);
        add_row(32'h55aa55aa, 3'd2, 1'b0);
        add_row(32'haa55aa55, 3'd4, 1'b1);
        for (int i = 0; i < 13; i++) add_row(32'hffffffff, 3'd0, 1'b0);
        add_row(32'h12345678, 3'd2, 1'b1);
        while (rows.size() > 0) send_item(rows.pop_front());

        n = 0;
        while (n < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: add_msg($urandom_range(12, 17));
                1: add_msg($urandom_range(28, 33));
                default: add_msg($urandom_range(0, 6));
            endcase
            if (n > RANDOM_ITEMS - 200) quiet = 1;
            while (rows.size() > 0) begin
                send_item(rows.pop_front());
                n++;
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        m_tready = 1'b0;
        hold_long = 1'b1;
        @(posedge aresetn);
        repeat (20) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        hold_long = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_long) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= int'($urandom_range(0, 9));
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        digest_item_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected item: digest_part %h final_part %b", m_tdata, m_tlast);
                errors++;
            end else begin
                e = digest_q.pop_front();
                if (m_tdata !== e.part) begin
                    $error("digest_part: expected %h, actual %h", e.part, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.fin) begin
                    $error("final_part: expected %b, actual %b", e.fin, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
    end

    initial begin
        idle_cnt = 0;
        rx_gap = 0;
        wait (stim_done && digest_q.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        wait (idle_cnt >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
